FILE: hdl/int64_divider_quotient_remainder_defines.svh
// Assertion helpers used by the checker of the divider.
`ifndef INT64_DIVIDER_QUOTIENT_REMAINDER_DEFINES_SVH
`define INT64_DIVIDER_QUOTIENT_REMAINDER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, reset included.
`define I64DIV_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent, ignored in reset.
`define I64DIV_ASSERT_NEXT_RST(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent, ignored in reset.
`define I64DIV_ASSERT_SAME_RST(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/i64div_pkg.sv
`default_nettype none

package i64div_pkg;

    localparam int DATA_W  = 64;
    localparam int N_CELLS = DATA_W;
    // One operand stage, one cell per quotient bit and one output stage.
    localparam int LATENCY = N_CELLS + 2;

    localparam logic [2:0] FUNC_UDIV32 = 3'd0;
    localparam logic [2:0] FUNC_SDIV32 = 3'd1;
    localparam logic [2:0] FUNC_UDIV64 = 3'd2;
    localparam logic [2:0] FUNC_SDIV64 = 3'd3;
    localparam logic [2:0] FUNC_UREM32 = 3'd4;
    localparam logic [2:0] FUNC_SREM32 = 3'd5;
    localparam logic [2:0] FUNC_UREM64 = 3'd6;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic want_rem;
        logic neg_res;
        logic div_zero;
        logic bad_func;
    } ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/int64_divider_quotient_remainder.sv
// Pipelined 64-bit integer divider. Each item gives an operation code on s_tuser and a
// dividend and divisor on s_tdata, and returns one quotient or remainder on m_tdata with
// a divide-by-zero flag on m_tuser. A new item is taken every cycle while s_tready is
// high. The pipe holds one stage that decodes the operation and takes operand
// magnitudes, a chain of 64 division cells that each settle one quotient bit, and an
// output register that applies the sign, the zero-divisor value or a zero result for an
// unknown code. Every stage holds its item while the next one is full, so back-pressure
// on m_ fills the pipe before s_tready falls. Write cfg_wdata with cfg_we only while the
// block is empty; its reset value is all ones.
`default_nettype none

module int64_divider_quotient_remainder (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [63:0]  cfg_wdata,     // zero_divide_value
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,       // [63:0] dividend, [127:64] divisor
    input  wire logic [7:0]   s_tuser,       // [2:0] func, [7:3] zero
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,       // [63:0] result
    output logic [7:0]        m_tuser        // [0] divide_by_zero, [7:1] zero
);
    import i64div_pkg::*;

    word_t zdv_reg;

    logic  chain_valid [N_CELLS+1];
    logic  chain_ready [N_CELLS+1];
    word_t chain_rem   [N_CELLS+1];
    word_t chain_quo   [N_CELLS+1];
    word_t chain_den   [N_CELLS+1];
    ctrl_t chain_ctrl  [N_CELLS+1];

    logic  div_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zdv_reg <= '1;
        end else if (cfg_we) begin
            zdv_reg <= cfg_wdata;
        end
    end

    i64div_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .func      (s_tuser[2:0]),
        .dividend  (s_tdata[DATA_W-1:0]),
        .divisor   (s_tdata[2*DATA_W-1:DATA_W]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_rem   (chain_rem[0]),
        .out_quo   (chain_quo[0]),
        .out_den   (chain_den[0]),
        .out_ctrl  (chain_ctrl[0])
    );

    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        i64div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_rem    (chain_rem[i]),
            .in_quo    (chain_quo[i]),
            .in_den    (chain_den[i]),
            .in_ctrl   (chain_ctrl[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_rem   (chain_rem[i+1]),
            .out_quo   (chain_quo[i+1]),
            .out_den   (chain_den[i+1]),
            .out_ctrl  (chain_ctrl[i+1])
        );
    end

    i64div_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (chain_valid[N_CELLS]),
        .in_ready     (chain_ready[N_CELLS]),
        .in_rem       (chain_rem[N_CELLS]),
        .in_quo       (chain_quo[N_CELLS]),
        .in_ctrl      (chain_ctrl[N_CELLS]),
        .zero_value   (zdv_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (m_tdata),
        .out_div_zero (div_zero)
    );

    assign m_tuser = {7'b0, div_zero};

endmodule

`default_nettype wire

FILE: hdl/i64div_prep.sv
`default_nettype none

module i64div_prep (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         func,
    input  wire i64div_pkg::word_t  dividend,
    input  wire i64div_pkg::word_t  divisor,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output i64div_pkg::word_t       out_rem,
    output i64div_pkg::word_t       out_quo,
    output i64div_pkg::word_t       out_den,
    output i64div_pkg::ctrl_t       out_ctrl
);
    import i64div_pkg::*;

    logic  is32;
    logic  sgn;
    logic  rem;
    logic  bad;
    word_t den_eff;
    logic  neg_a;
    logic  neg_b;
    word_t mag_a;
    word_t mag_b;
    ctrl_t ctrl_next;
    logic  load;

    logic  valid_reg, valid_next;
    word_t quo_reg;
    word_t den_reg;
    ctrl_t ctrl_reg;

    always_comb begin
        is32 = 1'b0;
        sgn  = 1'b0;
        rem  = 1'b0;
        bad  = 1'b0;
        unique case (func)
            FUNC_UDIV32: begin is32 = 1'b1; end
            FUNC_SDIV32: begin is32 = 1'b1; sgn = 1'b1; end
            FUNC_UDIV64: begin end
            FUNC_SDIV64: begin sgn = 1'b1; end
            FUNC_UREM32: begin is32 = 1'b1; rem = 1'b1; end
            FUNC_SREM32: begin is32 = 1'b1; sgn = 1'b1; rem = 1'b1; end
            FUNC_UREM64: begin rem = 1'b1; end
            default:     begin bad = 1'b1; end
        endcase
    end

    always_comb begin
        if (!is32) begin
            den_eff = divisor;
        end else if (sgn) begin
            den_eff = {{(DATA_W/2){divisor[DATA_W/2-1]}}, divisor[DATA_W/2-1:0]};
        end else begin
            den_eff = {{(DATA_W/2){1'b0}}, divisor[DATA_W/2-1:0]};
        end
        neg_a = sgn && dividend[DATA_W-1];
        neg_b = sgn && den_eff[DATA_W-1];
        mag_a = neg_a ? (~dividend + word_t'(1)) : dividend;
        mag_b = neg_b ? (~den_eff + word_t'(1)) : den_eff;
        // A remainder follows the dividend's sign, a quotient the sign of the pair.
        ctrl_next.want_rem = rem;
        ctrl_next.neg_res  = rem ? neg_a : (neg_a ^ neg_b);
        ctrl_next.div_zero = !bad && (den_eff == '0);
        ctrl_next.bad_func = bad;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            quo_reg  <= mag_a;
            den_reg  <= mag_b;
            ctrl_reg <= ctrl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = '0;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

`default_nettype wire

FILE: hdl/i64div_cell.sv
`default_nettype none

module i64div_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire i64div_pkg::word_t  in_rem,
    input  wire i64div_pkg::word_t  in_quo,
    input  wire i64div_pkg::word_t  in_den,
    input  wire i64div_pkg::ctrl_t  in_ctrl,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output i64div_pkg::word_t       out_rem,
    output i64div_pkg::word_t       out_quo,
    output i64div_pkg::word_t       out_den,
    output i64div_pkg::ctrl_t       out_ctrl
);
    import i64div_pkg::*;

    logic [DATA_W:0] shifted;
    logic [DATA_W:0] trial;
    logic            fits;
    logic            load;

    logic  valid_reg, valid_next;
    word_t rem_reg, rem_next;
    word_t quo_reg, quo_next;
    word_t den_reg;
    ctrl_t ctrl_reg;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb begin
        shifted  = {in_rem, in_quo[DATA_W-1]};
        trial    = shifted - {1'b0, in_den};
        fits     = !trial[DATA_W];
        rem_next = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_next = {in_quo[DATA_W-2:0], fits};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= in_den;
            ctrl_reg <= in_ctrl;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

`default_nettype wire

FILE: hdl/i64div_post.sv
`default_nettype none

module i64div_post (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire i64div_pkg::word_t  in_rem,
    input  wire i64div_pkg::word_t  in_quo,
    input  wire i64div_pkg::ctrl_t  in_ctrl,
    input  wire i64div_pkg::word_t  zero_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output i64div_pkg::word_t       out_result,
    output logic                    out_div_zero
);
    import i64div_pkg::*;

    word_t mag;
    word_t result_next;
    logic  load;

    logic  valid_reg, valid_next;
    word_t result_reg;
    logic  div_zero_reg;

    always_comb begin
        mag = in_ctrl.want_rem ? in_rem : in_quo;
        priority if (in_ctrl.bad_func) begin
            result_next = '0;
        end else if (in_ctrl.div_zero) begin
            result_next = zero_value;
        end else if (in_ctrl.neg_res) begin
            result_next = ~mag + word_t'(1);
        end else begin
            result_next = mag;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg   <= result_next;
            div_zero_reg <= in_ctrl.div_zero;
        end
    end

    assign out_valid    = valid_reg;
    assign out_result   = result_reg;
    assign out_div_zero = div_zero_reg;

endmodule

`default_nettype wire

FILE: hdl/i64div_checker.sv
`default_nettype none
`include "int64_divider_quotient_remainder_defines.svh"

module i64div_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic [7:0]   m_tuser
);
    import i64div_pkg::*;

    // A reset empties the whole pipe: no result is left and the input is free.
    `I64DIV_ASSERT_NEXT(a_reset_empties, aclk, !aresetn, !m_tvalid, "result left after reset")
    `I64DIV_ASSERT_NEXT(a_reset_ready, aclk, !aresetn, s_tready, "input not ready after reset")

    // A stalled result holds its data.
    `I64DIV_ASSERT_NEXT_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // No result can come out sooner than the pipe depth after reset ended.
    `I64DIV_ASSERT_SAME_RST(a_latency, aclk, aresetn, $rose(m_tvalid), $past(aresetn, LATENCY), "result faster than pipe depth")

endmodule

bind int64_divider_quotient_remainder i64div_checker u_i64div_checker (.*);

`default_nettype wire
